FILE: sv/pn3o_pkg.sv
package pn3o_pkg;

  // Fixed-point format and octave limit
  localparam int FRAC_BITS   = 16;
  localparam int MAX_OCTAVES = 4;
  localparam int ONE_Q       = 1 << FRAC_BITS;
  localparam int HALF_Q      = 1 << (FRAC_BITS - 1);

  // Reciprocal divide: avg = (total * M) >> REC_SHIFT, exact for totals below 2^21
  localparam int REC_SHIFT = 26;
  localparam logic [26:0] REC_DIV1  = 27'd67108864;
  localparam logic [26:0] REC_DIV3  = 27'd22369622;
  localparam logic [26:0] REC_DIV7  = 27'd9586981;
  localparam logic [26:0] REC_DIV15 = 27'd4473925;

  // Register map (word index)
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_MODE  = 2'd0;
  localparam reg_idx_t REG_COUNT = 2'd1;
  localparam reg_idx_t REG_SHIFT = 2'd2;

  typedef logic signed [21:0] nval_t;  // gradient dot products and blends
  typedef logic signed [17:0] off_t;   // corner offsets in [-1,1)
  typedef logic        [16:0] wgt_t;   // fractions and fade weights in [0,1]

  // Reference permutation
  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
    8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
    8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
    8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
    8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,8'd83,
    8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,8'd55,
    8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,
    8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,
    8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,
    8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,
    8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
    8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,
    8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
    8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,
    8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
    8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,
    8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
    8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,
    8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
    8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  // Unsigned product, rounded to nearest
  function automatic logic [20:0] qmul_u(input logic [20:0] a, input wgt_t b);
    logic [37:0] p;
    p = 38'(a) * 38'(b) + 38'(HALF_Q);
    return p[36:16];
  endfunction

  // a + w*(b-a), product rounded half away from zero
  function automatic nval_t blend(input nval_t a, input nval_t b, input wgt_t w);
    logic signed [22:0] d;
    logic        [22:0] mag;
    logic        [39:0] p;
    logic        [21:0] m;
    d   = 23'(b) - 23'(a);
    mag = d[22] ? 23'(-d) : 23'(d);
    p   = 40'(mag) * 40'(w) + 40'(HALF_Q);
    m   = p[37:16];
    return d[22] ? a - $signed(m) : a + $signed(m);
  endfunction

  // One of the 16 gradients dotted with the corner offset
  function automatic nval_t grad(input logic [3:0] h, input off_t x, input off_t y,
                                 input off_t z);
    off_t  u, v;
    nval_t su, sv;
    u  = (h < 4'd8) ? x : y;
    v  = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    su = h[0] ? -nval_t'(u) : nval_t'(u);
    sv = h[1] ? -nval_t'(v) : nval_t'(v);
    return su + sv;
  endfunction

  // Offset of the point from the near (d=0) or far (d=1) corner
  function automatic off_t frac_off(input logic [FRAC_BITS-1:0] f, input logic d);
    off_t o;
    o = off_t'({2'b00, f});
    return d ? o - off_t'(ONE_Q) : o;
  endfunction

  // Reciprocal for the weight sum 2^cnt - 1
  function automatic logic [26:0] recip(input logic [2:0] cnt);
    logic [26:0] r;
    case (cnt)
      3'd2:    r = REC_DIV3;
      3'd3:    r = REC_DIV7;
      3'd4:    r = REC_DIV15;
      default: r = REC_DIV1;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/pn3o_octave.sv
module pn3o_octave (
  input  logic        clk,
  input  logic [31:0] cx,
  input  logic [31:0] cy,
  input  logic [31:0] cz,
  input  logic [3:0]  sh,
  output logic [17:0] h
);
  import pn3o_pkg::*;

  logic [31:0] sc [3];

  logic [7:0]           xi_r [3];
  logic [FRAC_BITS-1:0] f1_r [3];

  logic [7:0]           a_r [2];
  logic [7:0]           yi2_r, zi2_r;
  wgt_t                 t2_r [3];
  logic [FRAC_BITS-1:0] f2_r [3];

  logic [7:0]           b_r [4];
  logic [7:0]           zi3_r;
  wgt_t                 t3_r [3];
  logic [20:0]          poly_r [3];
  logic [FRAC_BITS-1:0] f3_r [3];

  logic [7:0]           hh_r [8];
  wgt_t                 fd_r [3];
  logic [FRAC_BITS-1:0] f4_r [3];

  nval_t lx_r [4];
  wgt_t  v5_r, w5_r;
  nval_t ly_r [2];
  wgt_t  w6_r;
  nval_t n7;
  logic [17:0] h_r;

  off_t ox [2], oy [2], oz [2];

  // Scale by the octave frequency; wraps modulo 2^32
  always_comb begin
    sc[0] = cx << sh;
    sc[1] = cy << sh;
    sc[2] = cz << sh;
  end

  // Stage 1: lattice cell and fraction
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      xi_r[k] <= sc[k][FRAC_BITS+7:FRAC_BITS];
      f1_r[k] <= sc[k][FRAC_BITS-1:0];
    end
  end

  // Stage 2: first hash level, t^2
  always_ff @(posedge clk) begin
    a_r[0] <= PERM[xi_r[0]];
    a_r[1] <= PERM[xi_r[0] + 8'd1];
    yi2_r  <= xi_r[1];
    zi2_r  <= xi_r[2];
    for (int k = 0; k < 3; k++) begin
      t2_r[k] <= wgt_t'(qmul_u(21'(f1_r[k]), wgt_t'(f1_r[k])));
      f2_r[k] <= f1_r[k];
    end
  end

  // Stage 3: second hash level, t^3 and fade polynomial
  always_ff @(posedge clk) begin
    for (int dy = 0; dy < 2; dy++) begin
      for (int dx = 0; dx < 2; dx++) begin
        b_r[dy*2+dx] <= PERM[a_r[dx] + yi2_r + 8'(dy)];
      end
    end
    zi3_r <= zi2_r;
    for (int k = 0; k < 3; k++) begin
      t3_r[k]   <= wgt_t'(qmul_u(21'(t2_r[k]), wgt_t'(f2_r[k])));
      poly_r[k] <= 21'(t2_r[k]) * 21'd6 + 21'(10 * ONE_Q) - 21'(f2_r[k]) * 21'd15;
      f3_r[k]   <= f2_r[k];
    end
  end

  // Stage 4: corner hashes, fade weights
  always_ff @(posedge clk) begin
    for (int dz = 0; dz < 2; dz++) begin
      for (int c = 0; c < 4; c++) begin
        hh_r[dz*4+c] <= PERM[b_r[c] + zi3_r + 8'(dz)];
      end
    end
    for (int k = 0; k < 3; k++) begin
      fd_r[k] <= wgt_t'(qmul_u(poly_r[k], t3_r[k]));
      f4_r[k] <= f3_r[k];
    end
  end

  // Corner offsets
  always_comb begin
    for (int d = 0; d < 2; d++) begin
      ox[d] = frac_off(f4_r[0], d[0]);
      oy[d] = frac_off(f4_r[1], d[0]);
      oz[d] = frac_off(f4_r[2], d[0]);
    end
  end

  // Stage 5: gradients and blend along x
  always_ff @(posedge clk) begin
    for (int dz = 0; dz < 2; dz++) begin
      for (int dy = 0; dy < 2; dy++) begin
        lx_r[dz*2+dy] <= blend(grad(hh_r[dz*4+dy*2][3:0], ox[0], oy[dy], oz[dz]),
                               grad(hh_r[dz*4+dy*2+1][3:0], ox[1], oy[dy], oz[dz]),
                               fd_r[0]);
      end
    end
    v5_r <= fd_r[1];
    w5_r <= fd_r[2];
  end

  // Stage 6: blend along y
  always_ff @(posedge clk) begin
    ly_r[0] <= blend(lx_r[0], lx_r[1], v5_r);
    ly_r[1] <= blend(lx_r[2], lx_r[3], v5_r);
    w6_r    <= w5_r;
  end

  // Stage 7: blend along z, clamp to [-1,1], shift to [0,2]
  always_comb begin
    n7 = blend(ly_r[0], ly_r[1], w6_r);
    if (n7 > nval_t'(ONE_Q)) begin
      n7 = nval_t'(ONE_Q);
    end else if (n7 < -nval_t'(ONE_Q)) begin
      n7 = -nval_t'(ONE_Q);
    end
  end

  always_ff @(posedge clk) begin
    h_r <= 18'(n7 + nval_t'(ONE_Q));
  end

  assign h = h_r;

endmodule

FILE: sv/perlin_noise_3d_octaves.sv
// Improved 3D Perlin noise, optionally summed over up to four octaves.
// One request is taken every clock (busy stays low); its result shows on
// out_noise_value with the out_valid strobe, in request order. The receiver
// cannot stall, so each result is present for one cycle only. The path is the
// 7-stage per-octave pipeline (three dependent permutation lookups, fade
// products, three blend levels) followed by the weighted sum, the reciprocal
// divide multiply and the output register. Octaves run in parallel lanes.
// Change configuration only while idle.
module perlin_noise_3d_octaves (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  output logic               out_valid,
  output logic [15:0]        out_noise_value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pn3o_pkg::*;

  localparam int LAT = 10;

  logic       mode_r;
  logic [2:0] count_r, shift_r;
  logic [2:0] cnt, base;

  logic [LAT-1:0] v_r;
  logic [17:0]    h [MAX_OCTAVES];
  logic [20:0]    tot, tot_r;
  logic [47:0]    prod_r;
  logic [21:0]    avg;
  logic [20:0]    res;
  logic [15:0]    out_r;
  reg_idx_t       ridx;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign ridx   = paddr[3:2];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b1;
      count_r <= 3'd3;
      shift_r <= 3'd2;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_MODE:  mode_r  <= pwdata[0];
        REG_COUNT: count_r <= pwdata[2:0];
        REG_SHIFT: shift_r <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_MODE:  prdata = {31'd0, mode_r};
      REG_COUNT: prdata = {29'd0, count_r};
      REG_SHIFT: prdata = {29'd0, shift_r};
      default:   prdata = 32'd0;
    endcase
  end

  // Effective octave count and base shift
  always_comb begin
    if (mode_r) begin
      if (count_r == 3'd0) begin
        cnt = 3'd1;
      end else if (count_r > 3'(MAX_OCTAVES)) begin
        cnt = 3'(MAX_OCTAVES);
      end else begin
        cnt = count_r;
      end
      base = shift_r;
    end else begin
      cnt  = 3'd1;
      base = 3'd0;
    end
  end

  // Octave lanes
  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    pn3o_octave u_oct (
      .clk (clk),
      .cx  (in_coord_x),
      .cy  (in_coord_y),
      .cz  (in_coord_z),
      .sh  (4'(base) + 4'(i)),
      .h   (h[i])
    );
  end

  // Valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[LAT-2:0], start};
    end
  end

  // Weighted octave sum
  always_comb begin
    tot = '0;
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      if (3'(i) < cnt) begin
        tot = tot + (21'(h[i]) << i);
      end
    end
  end

  // Divide by the weight sum, then scale to 16 bits and saturate
  assign avg = prod_r[REC_SHIFT+21:REC_SHIFT];
  assign res = avg[21:1];

  always_ff @(posedge clk) begin
    tot_r  <= tot;
    prod_r <= 48'(tot_r) * 48'(recip(cnt));
    out_r  <= (res > 21'd65535) ? 16'hFFFF : res[15:0];
  end

  assign out_valid       = v_r[LAT-1];
  assign out_noise_value = out_r;

endmodule

FILE: tb/perlin_noise_3d_octaves_tb.sv
module perlin_noise_3d_octaves_tb;
  import pn3o_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 20;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_coord_x;
  logic signed [31:0] in_coord_y;
  logic signed [31:0] in_coord_z;
  logic               out_valid;
  logic [15:0]        out_noise_value;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  perlin_noise_3d_octaves u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_coord_z      (in_coord_z),
    .out_valid       (out_valid),
    .out_noise_value (out_noise_value),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Reference permutation, kept independent of the design's copy
  localparam byte unsigned PERM_TBL [256] = '{
    151,160,137,91,90,15,131,13,201,95,96,53,194,233,7,225,140,36,103,30,69,142,
    8,99,37,240,21,10,23,190,6,148,247,120,234,75,0,26,197,62,94,252,219,203,117,
    35,11,32,57,177,33,88,237,149,56,87,174,20,125,136,171,168,68,175,74,165,71,
    134,139,48,27,166,77,146,158,231,83,111,229,122,60,211,133,230,220,105,92,41,
    55,46,245,40,244,102,143,54,65,25,63,161,1,216,80,73,209,76,132,187,208,89,
    18,169,200,196,135,130,116,188,159,86,164,100,109,198,173,186,3,64,52,217,226,
    250,124,123,5,202,38,147,118,126,255,82,85,212,207,206,59,227,47,16,58,17,182,
    189,28,42,223,183,170,213,119,248,152,2,44,154,163,70,221,153,101,155,167,43,
    172,9,129,22,39,253,19,98,108,110,79,113,224,232,178,185,112,104,218,246,97,
    228,251,34,242,193,238,210,144,12,191,179,162,241,81,51,145,235,249,14,239,
    107,49,192,214,31,181,199,106,157,184,84,204,176,115,121,50,45,127,4,150,254,
    138,236,205,93,222,114,67,29,24,72,243,141,128,195,78,66,215,61,156,180
  };

  localparam longint Q1 = 64'sd65536;

  // Mirror of the configuration registers
  logic       mdl_mode;
  logic [2:0] mdl_count;
  logic [2:0] mdl_shift;

  logic [15:0] noise_expected_q[$];
  int          errors;
  int          cycles;
  logic        cur_lit;
  logic [15:0] cur_lit_val;
  bit          no_idle;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    bit          lit;
    logic [15:0] val;
  } point_row_t;

  // Lattice points give the midpoint in every mode; the rest go to the predictor
  point_row_t directed_rows[] = '{
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 16'd32768},
    '{32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000, 1'b1, 16'd32768},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 16'd32768},
    '{32'hFFFF_0000, 32'h0001_0000, 32'h00FF_0000, 1'b1, 16'd32768},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 16'd0},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 16'd0},
    '{32'h8000_0001, 32'h8000_0001, 32'h8000_0001, 1'b0, 16'd0},
    '{32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 1'b0, 16'd0},
    '{32'h0000_FFFF, 32'h0000_0001, 32'h0000_8000, 1'b0, 16'd0},
    '{32'hFFFF_8000, 32'h0000_4000, 32'hFFFF_C000, 1'b0, 16'd0},
    '{32'h0000_4000, 32'h0000_0000, 32'h0000_0000, 1'b0, 16'd0},
    '{32'h0000_0000, 32'h0000_4000, 32'h0000_0000, 1'b0, 16'd0},
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_4000, 1'b0, 16'd0},
    '{32'h0012_3456, 32'hFEDC_BA98, 32'h5555_AAAA, 1'b0, 16'd0},
    '{32'hAAAA_5555, 32'h0F0F_F0F0, 32'hF0F0_0F0F, 1'b0, 16'd0},
    '{32'h00FF_FFFF, 32'h0100_0000, 32'hFF00_0001, 1'b0, 16'd0}
  };

  // ---------------- predictor ----------------
  function automatic longint rmul(longint a, longint b);
    bit neg;
    longint unsigned ma, mb, m;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? longint'(-a) : a;
    mb  = (b < 0) ? longint'(-b) : b;
    m   = (ma * mb + 64'd32768) >> 16;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint quintic(longint t);
    longint t2, t3;
    t2 = rmul(t, t);
    t3 = rmul(t2, t);
    return rmul(t3, 6 * t2 - 15 * t + 10 * Q1);
  endfunction

  function automatic longint lerp_w(longint a, longint b, longint w);
    return a + rmul(w, b - a);
  endfunction

  function automatic longint corner_dot(int unsigned hv, longint x, longint y, longint z);
    logic [3:0] h;
    longint u, v;
    h = hv[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic int unsigned corner_hash(int unsigned x, int unsigned y,
                                              int unsigned z);
    int unsigned a, b;
    a = PERM_TBL[x & 255];
    b = PERM_TBL[(a + y) & 255];
    return PERM_TBL[(b + z) & 255];
  endfunction

  // One octave: noise + 1, clamped, in Q16.16
  function automatic longint octave_height(logic [31:0] cx, logic [31:0] cy,
                                           logic [31:0] cz, int sh);
    logic [31:0] sx, sy, sz;
    int unsigned xi, yi, zi;
    longint xf, yf, zf, u, v, w, x0, x1, y0, y1, n;
    sx = cx << sh;
    sy = cy << sh;
    sz = cz << sh;
    xi = sx[23:16];
    yi = sy[23:16];
    zi = sz[23:16];
    xf = sx[15:0];
    yf = sy[15:0];
    zf = sz[15:0];
    u  = quintic(xf);
    v  = quintic(yf);
    w  = quintic(zf);
    x0 = lerp_w(corner_dot(corner_hash(xi, yi, zi), xf, yf, zf),
                corner_dot(corner_hash(xi + 1, yi, zi), xf - Q1, yf, zf), u);
    x1 = lerp_w(corner_dot(corner_hash(xi, yi + 1, zi), xf, yf - Q1, zf),
                corner_dot(corner_hash(xi + 1, yi + 1, zi), xf - Q1, yf - Q1, zf), u);
    y0 = lerp_w(x0, x1, v);
    x0 = lerp_w(corner_dot(corner_hash(xi, yi, zi + 1), xf, yf, zf - Q1),
                corner_dot(corner_hash(xi + 1, yi, zi + 1), xf - Q1, yf, zf - Q1), u);
    x1 = lerp_w(corner_dot(corner_hash(xi, yi + 1, zi + 1), xf, yf - Q1, zf - Q1),
                corner_dot(corner_hash(xi + 1, yi + 1, zi + 1),
                           xf - Q1, yf - Q1, zf - Q1), u);
    y1 = lerp_w(x0, x1, v);
    n  = lerp_w(y0, y1, w);
    if (n > Q1) n = Q1;
    if (n < -Q1) n = -Q1;
    return n + Q1;
  endfunction

  function automatic logic [15:0] noise_height(logic [31:0] cx, logic [31:0] cy,
                                               logic [31:0] cz);
    int cnt, base;
    longint unsigned total, avg, r;
    cnt   = 1;
    base  = 0;
    total = 0;
    if (mdl_mode) begin
      cnt  = mdl_count;
      if (cnt < 1) cnt = 1;
      if (cnt > MAX_OCTAVES) cnt = MAX_OCTAVES;
      base = mdl_shift;
    end
    for (int i = 0; i < cnt; i++)
      total += longint'(octave_height(cx, cy, cz, base + i)) << i;
    avg = total / ((64'd1 << cnt) - 1);
    r   = (avg << 16) >> 17;
    if (r > 65535) r = 65535;
    return r[15:0];
  endfunction

  // ---------------- clock, timeout ----------------
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("perlin_noise_3d_octaves_tb NOT OK");
      $finish;
    end
  end

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Result checking and request capture, on pre-edge values
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (noise_expected_q.size() == 0)
        report("unexpected result", out_noise_value, 16'd0);
      else if (out_noise_value !== noise_expected_q[0]) begin
        report("noise_value", out_noise_value, noise_expected_q[0]);
        void'(noise_expected_q.pop_front());
      end else
        void'(noise_expected_q.pop_front());
    end
    if (rst_n && start && !busy)
      noise_expected_q.push_back(cur_lit ? cur_lit_val :
                                 noise_height(in_coord_x, in_coord_y, in_coord_z));
  end

  // ---------------- drivers ----------------
  task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODE:  mdl_mode  = val[0];
      REG_COUNT: mdl_count = val[2:0];
      REG_SHIFT: mdl_shift = val[2:0];
      default: ;
    endcase
  endtask

  // Reprogram only once the pipeline has drained
  task automatic set_mode(logic m, logic [2:0] c, logic [2:0] s);
    start <= 1'b0;
    while (noise_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write(REG_MODE, {31'd0, m});
    cfg_write(REG_COUNT, {29'd0, c});
    cfg_write(REG_SHIFT, {29'd0, s});
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            bit lit, logic [15:0] val);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_coord_x  <= x;
    in_coord_y  <= y;
    in_coord_z  <= z;
    cur_lit     <= lit;
    cur_lit_val <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    logic [31:0] c;
    case ($urandom_range(0, 5))
      0:       c = {16'($urandom_range(0, 65535)), 16'h0000};
      1:       c = {16'($urandom_range(0, 65535)), 16'hFFFF};
      2:       c = 32'($signed($urandom_range(0, 2048)) - 1024);
      3:       c = {16'($signed($urandom_range(0, 32)) - 16), 16'($urandom)};
      default: c = $urandom;
    endcase
    return c;
  endfunction

  task automatic random_points(int n);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, 16'd0);
  endtask

  // ---------------- sequence ----------------
  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_coord_x  = '0;
    in_coord_y  = '0;
    in_coord_z  = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    cur_lit     = 1'b0;
    cur_lit_val = '0;
    no_idle     = 1'b0;
    errors      = 0;
    cycles      = 0;
    mdl_mode    = 1'b1;
    mdl_count   = 3'd3;
    mdl_shift   = 3'd2;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset settings
    foreach (directed_rows[i])
      send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                 directed_rows[i].lit, directed_rows[i].val);
    random_points(30);

    // single noise at raw coordinates, then octave extremes
    set_mode(1'b0, 3'd4, 3'd4);
    foreach (directed_rows[i])
      send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                 directed_rows[i].lit, directed_rows[i].val);
    random_points(40);
    set_mode(1'b1, 3'd1, 3'd0);
    random_points(40);
    set_mode(1'b1, 3'd4, 3'd4);
    random_points(40);
    // count zero acts as one, count above max saturates, shift above four
    set_mode(1'b1, 3'd0, 3'd7);
    random_points(30);
    set_mode(1'b1, 3'd7, 3'd5);
    random_points(40);
    set_mode(1'b1, 3'd2, 3'd1);
    random_points(40);
    set_mode(1'b1, 3'd4, 3'd6);
    random_points(40);
    set_mode(1'b0, 3'd0, 3'd0);
    random_points(30);

    // back-to-back tail
    set_mode(1'b1, 3'd3, 3'd3);
    no_idle = 1'b1;
    random_points(50);
    start <= 1'b0;

    while (noise_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("perlin_noise_3d_octaves_tb OK");
    end else begin
      $display("perlin_noise_3d_octaves_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/pn3o_pkg.sv
sv/pn3o_octave.sv
sv/perlin_noise_3d_octaves.sv
tb/perlin_noise_3d_octaves_tb.sv
